// ----- rtl/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 2;

   localparam logic [INDEX_W-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_EXPONENT = 2'd1;

   // controller to datapath
   typedef struct packed {
      logic load;          // capture message and operands
      logic exp_shift;     // move to the next exponent bit
      logic mul_start;     // clear product, load operands
      logic mul_sel_base;  // multiplier is base (else running value)
      logic mul_step;      // one bit of the shift-and-add multiply
      logic mul_done;      // running value takes the product
      logic finish;        // load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reject;
      logic exp_zero;
      logic exp_msb;
   } sts_type;

endpackage

// ----- rtl/mexp_req_if.sv -----
// Request channel: one message word per item.
interface mexp_req_if import mexp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] message;

   modport source (output valid, output message, input ready);
   modport sink (input valid, input message, output ready);
endinterface

// ----- rtl/mexp_rsp_if.sv -----
// Response channel: result word and ok flag per item.
interface mexp_rsp_if import mexp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result;
   logic              ok;

   modport source (output valid, output result, output ok, input ready);
   modport sink (input valid, input result, input ok, output ready);
endinterface

// ----- rtl/mexp_dp.sv -----
// Datapath: config registers, exponent shifter, bit-serial modular multiplier.
module mexp_dp import mexp_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]  csr_wdata,
   input  logic [DATA_W-1:0]  message,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic [DATA_W-1:0]  result,
   output logic               ok
);

   logic [WIDTH-1:0] mod_cfg_ff, exp_cfg_ff;
   logic [WIDTH-1:0] mod_ff, base_ff, acc_ff, exp_ff;
   logic [WIDTH-1:0] pacc_ff, pa_ff, pb_ff;
   logic             reject_ff, ezero_ff;
   logic [DATA_W-1:0] result_ff;
   logic             ok_ff;

   logic [WIDTH-1:0] msg_op;
   logic [WIDTH:0]   dbl, sum, mod_x;
   logic [WIDTH-1:0] dbl_red, pacc_in, fin_val;

   assign msg_op = WIDTH'(message);
   assign mod_x  = {1'b0, mod_ff};

   // one multiplier bit: acc = 2*acc mod m, then + a mod m when the bit is set
   always_comb begin
      dbl     = {pacc_ff, 1'b0};
      dbl_red = (dbl >= mod_x) ? WIDTH'(dbl - mod_x) : WIDTH'(dbl);
      sum     = {1'b0, dbl_red} + {1'b0, pa_ff};
      if (pb_ff[WIDTH-1]) begin
         pacc_in = (sum >= mod_x) ? WIDTH'(sum - mod_x) : WIDTH'(sum);
      end else begin
         pacc_in = dbl_red;
      end
   end

   always_comb begin
      if (reject_ff) begin
         fin_val = '0;
      end else if (ezero_ff) begin
         fin_val = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
      end else begin
         fin_val = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_cfg_ff <= WIDTH'(2);
         exp_cfg_ff <= WIDTH'(1);
      end else if (csr_we) begin
         if (csr_index == CSR_MODULUS) begin
            mod_cfg_ff <= WIDTH'(csr_wdata);
         end else if (csr_index == CSR_EXPONENT) begin
            exp_cfg_ff <= WIDTH'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mod_ff    <= mod_cfg_ff;
         exp_ff    <= exp_cfg_ff;
         reject_ff <= (mod_cfg_ff == '0) || (msg_op > mod_cfg_ff);
         ezero_ff  <= (exp_cfg_ff == '0);
         // a message above the modulus is rejected, so the reduction is one compare
         base_ff   <= (msg_op == mod_cfg_ff) ? '0 : msg_op;
         acc_ff    <= (msg_op == mod_cfg_ff) ? '0 : msg_op;
      end else begin
         if (cmd.exp_shift) begin
            exp_ff <= {exp_ff[WIDTH-2:0], 1'b0};
         end
         if (cmd.mul_done) begin
            acc_ff <= pacc_ff;
         end
      end
      if (cmd.mul_start) begin
         pacc_ff <= '0;
         pa_ff   <= acc_ff;
         pb_ff   <= cmd.mul_sel_base ? base_ff : acc_ff;
      end else if (cmd.mul_step) begin
         pacc_ff <= pacc_in;
         pb_ff   <= {pb_ff[WIDTH-2:0], 1'b0};
      end
      if (cmd.finish) begin
         result_ff <= DATA_W'(fin_val);
         ok_ff     <= !reject_ff;
      end
   end

   assign sts.reject   = reject_ff;
   assign sts.exp_zero = ezero_ff;
   assign sts.exp_msb  = exp_ff[WIDTH-1];
   assign result       = result_ff;
   assign ok           = ok_ff;

endmodule

// ----- rtl/mexp_ctrl.sv -----
// Controller: sequences exponent bits and multiplies, owns the output valid.
module mexp_ctrl import mexp_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int CW = $clog2(WIDTH + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CHECK = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_SQ    = 8'b0000_1000,
      ST_BM    = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_MDONE = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] ecnt_ff, ecnt_in;   // exponent bits left, current one included
   logic [CW-1:0] mcnt_ff, mcnt_in;
   logic          sq_ff, sq_in;
   logic          out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      ecnt_in      = ecnt_ff;
      mcnt_in      = mcnt_ff;
      sq_in        = sq_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.reject || sts.exp_zero) begin
               state_in = ST_FIN;
            end else begin
               ecnt_in  = CW'(WIDTH);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // drop leading zeros and the top set bit itself
            cmd.exp_shift = 1'b1;
            ecnt_in       = ecnt_ff - CW'(1);
            if (sts.exp_msb) begin
               state_in = (ecnt_ff == CW'(1)) ? ST_FIN : ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.mul_start = 1'b1;
            mcnt_in       = CW'(WIDTH);
            sq_in         = 1'b1;
            state_in      = ST_MUL;
         end
         ST_BM: begin
            cmd.mul_start    = 1'b1;
            cmd.mul_sel_base = 1'b1;
            mcnt_in          = CW'(WIDTH);
            sq_in            = 1'b0;
            state_in         = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            mcnt_in      = mcnt_ff - CW'(1);
            if (mcnt_ff == CW'(1)) begin
               state_in = ST_MDONE;
            end
         end
         ST_MDONE: begin
            cmd.mul_done = 1'b1;
            if (sq_ff && sts.exp_msb) begin
               state_in = ST_BM;
            end else begin
               cmd.exp_shift = 1'b1;
               ecnt_in       = ecnt_ff - CW'(1);
               state_in      = (ecnt_ff == CW'(1)) ? ST_FIN : ST_SQ;
            end
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         ecnt_ff      <= '0;
         mcnt_ff      <= '0;
         sq_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         ecnt_ff      <= ecnt_in;
         mcnt_ff      <= mcnt_in;
         sq_ff        <= sq_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

// ----- rtl/modular_exponentiation.sv -----
// Top level: message^exponent mod modulus by left-to-right square-and-multiply.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        message[31:0]
//   rsp_ch   out        valid/ready        result[31:0], ok
//   csr      in         csr_we (no wait)   csr_index[1:0], csr_wdata[31:0]
//
// Each multiply is bit-serial: a setup step, a step per multiplier bit, then a writeback.
// Rejected messages and exponent zero go from the check straight to the finish step.
// A new item is taken while a result waits in the output register; the finished
// result of that next item stalls until the output register frees.
// Reset is synchronous; modulus resets to 2 and exponent to 1.
module modular_exponentiation import mexp_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   mexp_req_if.sink           req_ch,
   mexp_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]  csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mexp_dp #(.WIDTH(WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .message   (req_ch.message),
      .cmd       (cmd),
      .sts       (sts),
      .result    (rsp_ch.result),
      .ok        (rsp_ch.ok)
   );

   // a rejected item always carries a zero result
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ok |-> rsp_ch.result == '0)
      else $error("rejected item with nonzero result");

   // the output register is never overwritten while it holds an untaken item
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_ch.valid || rsp_ch.ready)
      else $error("result overwritten");

   // no new item is taken while the multiplier is busy
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !cmd.mul_step && !cmd.mul_start)
      else $error("ready while busy");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_start, cmd.mul_step, cmd.finish}))
      else $error("conflicting datapath commands");

   // a finished item becomes visible on the next cycle
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_ch.valid)
      else $error("finished item not presented");

endmodule
